/* rtl/ilp_pkg.sv */
// shared types and codes for the integer literal parser
// used by ilp_step and integer_literal_parser; depends on nothing else
package ilp_pkg;

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;
   localparam logic [1:0] RADIX_BIN = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam int unsigned ACC_W   = 64;
   localparam int unsigned VALUE_W = 32;

   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [1:0]       pos;
      logic [1:0]       radix;
      logic             digit_seen;
      logic             bad_tail;
      logic             wide_ovf;
      logic             hex_pending;
   } parse_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      acc:         '0,
      pos:         2'd0,
      radix:       RADIX_DEC,
      digit_seen:  1'b0,
      bad_tail:    1'b0,
      wide_ovf:    1'b0,
      hex_pending: 1'b0
   };

endpackage

/* rtl/ilp_step.sv */
// per-character step of the literal parser: next parse state and final result
// combinational only; depends on ilp_pkg
module ilp_step (
   input  logic [7:0]                 char_code,
   input  logic                       last_char,
   input  ilp_pkg::parse_state_type   cur_state,
   output ilp_pkg::parse_state_type   next_state,
   output ilp_pkg::parse_result_type  result
);

   localparam logic [5:0] DIGIT_NONE = 6'd63;
   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_LZ = 8'h7a;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_UZ = 8'h5a;
   localparam logic [7:0] CH_LX = 8'h78;
   localparam logic [7:0] CH_UX = 8'h58;
   localparam logic [7:0] CH_LO = 8'h6f;
   localparam logic [7:0] CH_UO = 8'h4f;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_UB = 8'h42;

   localparam int unsigned EXT_W = ilp_pkg::ACC_W + 4;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'hff;
         if (c >= CH_0 && c <= CH_9) d = c - CH_0;
         else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 8'd10;
         else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 8'd10;
         digit_of = (d == 8'hff) ? DIGIT_NONE : d[5:0];
      end
   endfunction

   logic [5:0]       digit;
   logic [5:0]       base;
   logic             digit_ok;
   logic             is_x;
   logic             is_prefix_char;
   logic             acc_zero;
   logic [EXT_W-1:0] acc_ext;
   logic [EXT_W-1:0] digit_ext;
   logic [EXT_W-1:0] mul_add;
   logic             take_ovf;
   ilp_pkg::parse_state_type upd;

   assign digit          = digit_of(char_code);
   assign is_x           = (char_code == CH_LX) || (char_code == CH_UX);
   assign is_prefix_char = is_x || (char_code == CH_LO) || (char_code == CH_UO) ||
                           (char_code == CH_LB) || (char_code == CH_UB);
   assign acc_zero       = (cur_state.acc == '0);
   assign acc_ext        = {4'd0, cur_state.acc};
   assign digit_ext      = {{(EXT_W-6){1'b0}}, digit};

   always_comb begin
      case (cur_state.radix)
         ilp_pkg::RADIX_DEC: base = 6'd10;
         ilp_pkg::RADIX_HEX: base = 6'd16;
         ilp_pkg::RADIX_OCT: base = 6'd8;
         ilp_pkg::RADIX_BIN: base = 6'd2;
         default:            base = 6'd10;
      endcase
   end

   assign digit_ok = (digit < base);

   // exact product-plus-digit; any bit at or above bit 64 means the run no longer fits
   always_comb begin
      case (cur_state.radix)
         ilp_pkg::RADIX_DEC: mul_add = (acc_ext << 3) + (acc_ext << 1) + digit_ext;
         ilp_pkg::RADIX_HEX: mul_add = (acc_ext << 4) + digit_ext;
         ilp_pkg::RADIX_OCT: mul_add = (acc_ext << 3) + digit_ext;
         ilp_pkg::RADIX_BIN: mul_add = (acc_ext << 1) + digit_ext;
         default:            mul_add = acc_ext;
      endcase
   end

   assign take_ovf = (mul_add[EXT_W-1:ilp_pkg::ACC_W] != 4'd0);

   always_comb begin
      upd = cur_state;
      if (cur_state.radix == ilp_pkg::RADIX_DEC && cur_state.pos == 2'd1 &&
          cur_state.digit_seen && acc_zero && !cur_state.bad_tail &&
          !cur_state.wide_ovf && is_prefix_char) begin
         if (is_x) upd.radix = ilp_pkg::RADIX_HEX;
         else if (char_code == CH_LO || char_code == CH_UO) upd.radix = ilp_pkg::RADIX_OCT;
         else upd.radix = ilp_pkg::RADIX_BIN;
         upd.digit_seen = 1'b0;
         upd.pos        = 2'd0;
      end else begin
         if (!cur_state.bad_tail) begin
            if (cur_state.hex_pending) begin
               // base is already 16 here, a pending prefix only arises in hex
               upd.hex_pending = 1'b0;
               if (digit_ok) begin
                  upd.digit_seen = 1'b1;
                  if (!cur_state.wide_ovf) begin
                     if (take_ovf) upd.wide_ovf = 1'b1;
                     else upd.acc = mul_add[ilp_pkg::ACC_W-1:0];
                  end
               end else begin
                  upd.bad_tail = 1'b1;
               end
            end else if (cur_state.radix == ilp_pkg::RADIX_HEX && cur_state.pos == 2'd1 &&
                         cur_state.digit_seen && acc_zero && is_x) begin
               upd.hex_pending = 1'b1;
            end else if (digit_ok) begin
               upd.digit_seen = 1'b1;
               if (!cur_state.wide_ovf) begin
                  if (take_ovf) upd.wide_ovf = 1'b1;
                  else upd.acc = mul_add[ilp_pkg::ACC_W-1:0];
               end
            end else begin
               upd.bad_tail = 1'b1;
            end
         end
         if (cur_state.pos != 2'd3) upd.pos = cur_state.pos + 2'd1;
      end
   end

   always_comb begin
      if (upd.wide_ovf) begin
         result.value  = '1;
         result.status = ilp_pkg::STATUS_SATURATED;
      end else if (!upd.digit_seen || upd.bad_tail || upd.hex_pending) begin
         result.value  = '0;
         result.status = ilp_pkg::STATUS_INVALID;
      end else if (upd.acc[ilp_pkg::ACC_W-1:ilp_pkg::VALUE_W] != '0) begin
         result.value  = '1;
         result.status = ilp_pkg::STATUS_SATURATED;
      end else begin
         result.value  = upd.acc[ilp_pkg::VALUE_W-1:0];
         result.status = ilp_pkg::STATUS_OK;
      end
   end

   assign next_state = last_char ? ilp_pkg::STATE_RESET : upd;

endmodule

/* rtl/integer_literal_parser.sv */
// top level of the radix-prefixed integer literal parser
// holds the input, parse state and result registers; depends on ilp_pkg, ilp_step
//
// usage: send the literal one byte per item on req_char_code, with req_last_char
// high on the final byte. a leading 0x / 0o / 0b (any case) selects base 16 / 8 / 2,
// otherwise base 10. exactly one result item comes out per literal, on the rsp_
// channel: rsp_number_value and rsp_parse_status (ok, invalid, saturated).
// non-final bytes produce nothing.
// timing: one item is taken per cycle while req_stall is low. a byte is first captured
// in the input register and then folded into the parse state, where a final byte also
// loads the result register, so the result passes the input and result registers in
// turn. the per-byte work is a 68-bit shift-add and a compare in ilp_step.
// when the receiver stalls, the result holds in the output register and the input
// register still drains non-final bytes; req_stall rises only when a final byte
// sits in the input register and the output register is full and stalled.
// reset (synchronous, active high) drops both valids and returns the parse state
// to decimal with an empty accumulator.
module integer_literal_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_number_value,
   output logic [1:0]  rsp_parse_status
);

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff;
   logic       stage_last_ff;
   logic       stage_go;
   logic       out_free;
   logic       req_take;

   ilp_pkg::parse_state_type  state_ff, state_in;
   ilp_pkg::parse_result_type step_result;
   ilp_pkg::parse_result_type result_ff;
   logic                      result_valid_ff, result_valid_in;

   ilp_step u_step (
      .char_code  (stage_char_ff),
      .last_char  (stage_last_ff),
      .cur_state  (state_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   assign out_free  = !result_valid_ff || !rsp_stall;
   // a non-final item never needs the output register
   assign stage_go  = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_stall = stage_valid_ff && !stage_go;
   assign req_take  = req_valid && !req_stall;

   assign stage_valid_in  = req_take || (stage_valid_ff && !stage_go);
   assign result_valid_in = (stage_go && stage_last_ff) || (result_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
         state_ff        <= ilp_pkg::STATE_RESET;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         result_valid_ff <= result_valid_in;
         if (stage_go) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_char_ff <= req_char_code;
         stage_last_ff <= req_last_char;
      end
      if (stage_go && stage_last_ff) result_ff <= step_result;
   end

   assign rsp_valid        = result_valid_ff;
   assign rsp_number_value = result_ff.value;
   assign rsp_parse_status = result_ff.status;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parse_status == ilp_pkg::STATUS_OK ||
                     rsp_parse_status == ilp_pkg::STATUS_INVALID ||
                     rsp_parse_status == ilp_pkg::STATUS_SATURATED))
      else $error("result status out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_status == ilp_pkg::STATUS_INVALID) |-> rsp_number_value == '0)
      else $error("invalid literal with nonzero value");

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_status == ilp_pkg::STATUS_SATURATED) |-> rsp_number_value == '1)
      else $error("saturated literal not all ones");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (stage_go && stage_last_ff) |=> state_ff == ilp_pkg::STATE_RESET)
      else $error("parse state not cleared after final item");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid_ff && stage_last_ff && result_valid_ff && rsp_stall))
      else $error("input stalled without a blocked final item");

endmodule
